[design/cabn_pkg.sv]
// Package for the class-aware box NMS block: field widths, reset values,
// sequencer state encoding and small helper functions.
// No dependencies.
`default_nettype none
package cabn_pkg;

  localparam int DEF_MAX_BOXES = 64;
  localparam int COORD_W       = 16;
  localparam int SCORE_W       = 16;
  localparam int CLASS_W       = 8;
  localparam int RANK_W        = SCORE_W + CLASS_W;
  localparam int CORNER_W      = 4 * COORD_W;
  localparam int THR_W         = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

  // Sequencer states, one-hot
  typedef enum logic [17:0] {
    S_LOAD      = 18'h00001,
    S_RK_RD     = 18'h00002,
    S_RK_LATCH  = 18'h00004,
    S_RK_SWEEP  = 18'h00008,
    S_RK_WRITE  = 18'h00010,
    S_SP_RD_I   = 18'h00020,
    S_SP_GET_I  = 18'h00040,
    S_SP_AREA_I = 18'h00080,
    S_SP_RD_J   = 18'h00100,
    S_SP_GET_J  = 18'h00200,
    S_SP_MUL_I  = 18'h00400,
    S_SP_MUL_A  = 18'h00800,
    S_SP_UNI    = 18'h01000,
    S_SP_CMP    = 18'h02000,
    S_SP_NEXT_I = 18'h04000,
    S_OUT_RD    = 18'h08000,
    S_OUT_GET   = 18'h10000,
    S_OUT_EMPTY = 18'h20000
  } state_t;

  // Side length, zero when the corners are reversed
  function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                              input logic [COORD_W-1:0] hi);
    span = (hi > lo) ? (hi - lo) : '0;
  endfunction

  // Rank is {class, score}: higher class first, then higher score
  function automatic logic ranks_before(input logic [RANK_W-1:0] ra,
                                        input logic [RANK_W-1:0] rb);
    if (ra[RANK_W-1:SCORE_W] != rb[RANK_W-1:SCORE_W])
      ranks_before = ra[RANK_W-1:SCORE_W] > rb[RANK_W-1:SCORE_W];
    else
      ranks_before = ra[SCORE_W-1:0] > rb[SCORE_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/class_aware_box_nms.sv]
// Class-aware box NMS: loads a set of boxes, ranks them, suppresses overlaps
// per class with one shared multiplier and streams out the survivors.
// Depends on cabn_pkg.
// Loading: one box per cycle while idle. After the last box of a set, ranking
// does one rank compare per cycle, suppression works through the same-class
// pairs and each box with the one multiplier, and output reads each stored box
// and waits on output stalls. Input is not ready from the last box until the
// final result has been loaded into the output register.
// Reset (rst_n low, synchronous) empties the set and sets the threshold to 0.5.
`default_nettype none
module class_aware_box_nms #(
  parameter int MAX_BOXES = cabn_pkg::DEF_MAX_BOXES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // left_x, top_y, right_x, bottom_y, confidence, class_label
  input  wire logic [87:0] in_tdata,
  input  wire logic        in_tlast,   // last_box
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_left_x, out_top_y, out_right_x, out_bottom_y, out_confidence, out_class
  output logic [87:0]      out_tdata,
  // empty_set, overflowed
  output logic [1:0]       out_tuser,
  output logic             out_tlast,  // last_result
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // IoU threshold, Q0.16
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int CW    = cabn_pkg::COORD_W;
  localparam int RW    = cabn_pkg::RANK_W;
  localparam int SW    = cabn_pkg::SCORE_W;

  cabn_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  box_count_r, box_count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [15:0]       thr_r;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  surv_r, surv_nxt, em_r, em_nxt;
  logic [MAX_BOXES-1:0] kept_r, kept_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  // payload registers
  logic [RW-1:0]     ri_r, ri_nxt;
  logic [cabn_pkg::CORNER_W-1:0] ci_r, ci_nxt;
  logic [CW-1:0]     pw_r, pw_nxt, ph_r, ph_nxt, qw_r, qw_nxt, qh_r, qh_nxt;
  logic [31:0]       ai_r, ai_nxt, inter_r, inter_nxt, aj_r, aj_nxt;
  logic [32:0]       uni_r, uni_nxt;
  logic [87:0]       out_tdata_r, out_tdata_nxt;
  logic [1:0]        out_tuser_r, out_tuser_nxt;
  logic              out_tlast_r, out_tlast_nxt;

  // memories: arrival order and sorted order
  logic [cabn_pkg::CORNER_W-1:0] corner_mem [MAX_BOXES];
  logic [RW-1:0]                 rank_mem   [MAX_BOXES];
  logic [cabn_pkg::CORNER_W-1:0] scorner_mem [MAX_BOXES];
  logic [RW-1:0]                 srank_mem   [MAX_BOXES];
  logic [cabn_pkg::CORNER_W-1:0] corner_q, scorner_q;
  logic [RW-1:0]                 rank_q, srank_q;
  logic [IDX_W-1:0]              rd_addr, srd_addr;

  logic in_fire, out_fire, out_free, load_wr, rk_wr;
  logic [CNT_W-1:0] n_last;
  logic i_is_last, j_is_last;

  // shared multiplier
  logic [15:0] mul_a;
  logic [32:0] mul_b;
  logic [48:0] prod;

  // corners of the intersection of box i and box j
  logic [CW-1:0] x1, y1, x2, y2;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid_r && out_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == cabn_pkg::S_LOAD);
  assign cfg_ready = 1'b1;
  assign load_wr   = in_fire && (box_count_r < CNT_W'(MAX_BOXES));
  assign rk_wr     = (state_r == cabn_pkg::S_RK_WRITE);
  assign n_last    = box_count_r - CNT_W'(1);
  assign i_is_last = (CNT_W'(i_r) == n_last);
  assign j_is_last = (CNT_W'(j_r) == n_last);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign prod = {33'b0, mul_a} * {16'b0, mul_b};

  assign x1 = (ci_r[15:0]  > scorner_q[15:0])  ? ci_r[15:0]  : scorner_q[15:0];
  assign y1 = (ci_r[31:16] > scorner_q[31:16]) ? ci_r[31:16] : scorner_q[31:16];
  assign x2 = (ci_r[47:32] < scorner_q[47:32]) ? ci_r[47:32] : scorner_q[47:32];
  assign y2 = (ci_r[63:48] < scorner_q[63:48]) ? ci_r[63:48] : scorner_q[63:48];

  // multiplier operand select
  always_comb begin
    mul_a = pw_r;
    mul_b = {17'b0, ph_r};
    unique case (state_r)
      cabn_pkg::S_SP_MUL_A: begin
        mul_a = qw_r;
        mul_b = {17'b0, qh_r};
      end
      cabn_pkg::S_SP_CMP: begin
        mul_a = thr_r;
        mul_b = uni_r;
      end
      default: ;
    endcase
  end

  // read addresses
  always_comb begin
    rd_addr = i_r;
    if (state_r == cabn_pkg::S_RK_LATCH)
      rd_addr = '0;
    else if (state_r == cabn_pkg::S_RK_SWEEP)
      rd_addr = IDX_W'(j_r + 1'b1);
    srd_addr = (state_r == cabn_pkg::S_SP_RD_J) ? j_r : i_r;
  end

  // memories
  always_ff @(posedge clk) begin
    if (load_wr) begin
      corner_mem[box_count_r[IDX_W-1:0]] <= in_tdata[63:0];
      rank_mem[box_count_r[IDX_W-1:0]]   <= in_tdata[87:64];
    end
    corner_q <= corner_mem[rd_addr];
    rank_q   <= rank_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rk_wr) begin
      scorner_mem[cnt_r] <= ci_r;
      srank_mem[cnt_r]   <= ri_r;
    end
    scorner_q <= scorner_mem[srd_addr];
    srank_q   <= srank_mem[srd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    box_count_nxt  = box_count_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    surv_nxt       = surv_r;
    em_nxt         = em_r;
    kept_nxt       = kept_r;
    out_tvalid_nxt = out_fire ? 1'b0 : out_tvalid_r;
    ri_nxt         = ri_r;
    ci_nxt         = ci_r;
    pw_nxt         = pw_r;
    ph_nxt         = ph_r;
    qw_nxt         = qw_r;
    qh_nxt         = qh_r;
    ai_nxt         = ai_r;
    inter_nxt      = inter_r;
    aj_nxt         = aj_r;
    uni_nxt        = uni_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;

    unique case (state_r)
      cabn_pkg::S_LOAD: begin
        if (in_fire) begin
          if (load_wr) box_count_nxt = box_count_r + CNT_W'(1);
          else         ovf_nxt = 1'b1;
          if (in_tlast) begin
            i_nxt     = '0;
            surv_nxt  = '0;
            em_nxt    = '0;
            state_nxt = cabn_pkg::S_RK_RD;
          end
        end
      end
      cabn_pkg::S_RK_RD: state_nxt = cabn_pkg::S_RK_LATCH;
      cabn_pkg::S_RK_LATCH: begin
        ri_nxt    = rank_q;
        ci_nxt    = corner_q;
        j_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = cabn_pkg::S_RK_SWEEP;
      end
      // count boxes that rank ahead of box i
      cabn_pkg::S_RK_SWEEP: begin
        if (cabn_pkg::ranks_before(rank_q, ri_r) || (rank_q == ri_r && j_r < i_r))
          cnt_nxt = cnt_r + IDX_W'(1);
        if (j_is_last) state_nxt = cabn_pkg::S_RK_WRITE;
        else           j_nxt = j_r + IDX_W'(1);
      end
      cabn_pkg::S_RK_WRITE: begin
        kept_nxt[cnt_r] = (ri_r[SW-1:0] != '0);
        if (ri_r[SW-1:0] != '0) surv_nxt = surv_r + CNT_W'(1);
        if (i_is_last) begin
          i_nxt     = '0;
          state_nxt = cabn_pkg::S_SP_RD_I;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = cabn_pkg::S_RK_RD;
        end
      end
      cabn_pkg::S_SP_RD_I: state_nxt = cabn_pkg::S_SP_GET_I;
      cabn_pkg::S_SP_GET_I: begin
        if (!kept_r[i_r]) begin
          state_nxt = cabn_pkg::S_SP_NEXT_I;
        end else begin
          ci_nxt    = scorner_q;
          ri_nxt    = srank_q;
          pw_nxt    = cabn_pkg::span(scorner_q[15:0], scorner_q[47:32]);
          ph_nxt    = cabn_pkg::span(scorner_q[31:16], scorner_q[63:48]);
          state_nxt = cabn_pkg::S_SP_AREA_I;
        end
      end
      cabn_pkg::S_SP_AREA_I: begin
        ai_nxt = prod[31:0];
        if (i_is_last) begin
          state_nxt = cabn_pkg::S_SP_NEXT_I;
        end else begin
          j_nxt     = i_r + IDX_W'(1);
          state_nxt = cabn_pkg::S_SP_RD_J;
        end
      end
      cabn_pkg::S_SP_RD_J: state_nxt = cabn_pkg::S_SP_GET_J;
      cabn_pkg::S_SP_GET_J: begin
        priority if (srank_q[RW-1:SW] != ri_r[RW-1:SW]) begin
          state_nxt = cabn_pkg::S_SP_NEXT_I;
        end else if (!kept_r[j_r]) begin
          if (j_is_last) state_nxt = cabn_pkg::S_SP_NEXT_I;
          else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = cabn_pkg::S_SP_RD_J;
          end
        end else begin
          pw_nxt    = cabn_pkg::span(x1, x2);
          ph_nxt    = cabn_pkg::span(y1, y2);
          qw_nxt    = cabn_pkg::span(scorner_q[15:0], scorner_q[47:32]);
          qh_nxt    = cabn_pkg::span(scorner_q[31:16], scorner_q[63:48]);
          state_nxt = cabn_pkg::S_SP_MUL_I;
        end
      end
      cabn_pkg::S_SP_MUL_I: begin
        inter_nxt = prod[31:0];
        state_nxt = cabn_pkg::S_SP_MUL_A;
      end
      cabn_pkg::S_SP_MUL_A: begin
        aj_nxt    = prod[31:0];
        state_nxt = cabn_pkg::S_SP_UNI;
      end
      cabn_pkg::S_SP_UNI: begin
        uni_nxt   = {1'b0, ai_r} + {1'b0, aj_r} - {1'b0, inter_r};
        state_nxt = cabn_pkg::S_SP_CMP;
      end
      // inter * 2^16 > thr * union, skipped on zero union
      cabn_pkg::S_SP_CMP: begin
        if (uni_r != '0 && {1'b0, inter_r, 16'h0} > prod) begin
          kept_nxt[j_r] = 1'b0;
          surv_nxt      = surv_r - CNT_W'(1);
        end
        if (j_is_last) state_nxt = cabn_pkg::S_SP_NEXT_I;
        else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = cabn_pkg::S_SP_RD_J;
        end
      end
      cabn_pkg::S_SP_NEXT_I: begin
        if (i_is_last) begin
          i_nxt     = '0;
          state_nxt = (surv_r == '0) ? cabn_pkg::S_OUT_EMPTY : cabn_pkg::S_OUT_RD;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = cabn_pkg::S_SP_RD_I;
        end
      end
      cabn_pkg::S_OUT_RD: state_nxt = cabn_pkg::S_OUT_GET;
      cabn_pkg::S_OUT_GET: begin
        if (!kept_r[i_r] || out_free) begin
          if (kept_r[i_r]) begin
            out_tvalid_nxt = 1'b1;
            out_tdata_nxt  = {srank_q, scorner_q};
            out_tuser_nxt  = {ovf_r, 1'b0};
            out_tlast_nxt  = (em_r == surv_r - CNT_W'(1));
            em_nxt         = em_r + CNT_W'(1);
          end
          if (i_is_last) begin
            box_count_nxt = '0;
            ovf_nxt       = 1'b0;
            kept_nxt      = '0;
            state_nxt     = cabn_pkg::S_LOAD;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = cabn_pkg::S_OUT_RD;
          end
        end
      end
      cabn_pkg::S_OUT_EMPTY: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          out_tuser_nxt  = {ovf_r, 1'b1};
          out_tlast_nxt  = 1'b1;
          box_count_nxt  = '0;
          ovf_nxt        = 1'b0;
          kept_nxt       = '0;
          state_nxt      = cabn_pkg::S_LOAD;
        end
      end
      default: state_nxt = cabn_pkg::S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cabn_pkg::S_LOAD;
      box_count_r  <= '0;
      ovf_r        <= 1'b0;
      thr_r        <= cabn_pkg::THR_RESET;
      i_r          <= '0;
      j_r          <= '0;
      cnt_r        <= '0;
      surv_r       <= '0;
      em_r         <= '0;
      kept_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      box_count_r  <= box_count_nxt;
      ovf_r        <= ovf_nxt;
      if (cfg_valid && cfg_ready) thr_r <= cfg_data;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      cnt_r        <= cnt_nxt;
      surv_r       <= surv_nxt;
      em_r         <= em_nxt;
      kept_r       <= kept_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ri_r        <= ri_nxt;
    ci_r        <= ci_nxt;
    pw_r        <= pw_nxt;
    ph_r        <= ph_nxt;
    qw_r        <= qw_nxt;
    qh_r        <= qh_nxt;
    ai_r        <= ai_nxt;
    inter_r     <= inter_nxt;
    aj_r        <= aj_nxt;
    uni_r       <= uni_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

`ifndef SYNTHESIS
  // survivor count never exceeds the set size
  a_surv_le_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cabn_pkg::S_LOAD) |-> (surv_r <= box_count_r))
    else $error("survivor count above set size");

  // never more results than survivors
  a_em_le_surv: assert property (@(posedge clk) disable iff (!rst_n)
    (em_r <= surv_r || state_r == cabn_pkg::S_LOAD))
    else $error("emitted more results than survivors");

  // keep mask is clear whenever a new set is being loaded
  a_kept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cabn_pkg::S_LOAD) |-> (kept_r == '0))
    else $error("keep mask not cleared between sets");

  // store fill stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    box_count_r <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");
`endif

endmodule
`default_nettype wire

[tb/tb_class_aware_box_nms.sv]
// Self-checking testbench for class_aware_box_nms: boxes are streamed in sets,
// and every result is checked against a behavioural NMS predictor or a table entry.
// Depends on cabn_pkg and the class_aware_box_nms RTL.
`default_nettype none
module tb_class_aware_box_nms;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBOX       = cabn_pkg::DEF_MAX_BOXES;
  localparam int IDLE_LIMIT = 100000;  // generous: covers a full 64-box set
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE     = 16;

  // left_x sits in the lowest bits, exactly as on in_tdata / out_tdata
  typedef struct packed {
    logic [7:0]  cls;
    logic [15:0] conf;
    logic [15:0] bottom;
    logic [15:0] right;
    logic [15:0] top;
    logic [15:0] left;
  } box_t;

  typedef struct packed {
    box_t b;
    logic empty;
    logic ovf;
    logic last;
  } kept_t;

  typedef struct {
    box_t  b;
    bit    last;
    bit    typed;  // expectation written into the table rather than predicted
    kept_t r;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  class_aware_box_nms u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  box_t        open_set[$];
  bit          open_ovf;
  logic [15:0] nms_thr;
  kept_t       kept_q[$];

  int errors;
  int boxes_sent;
  int sets_closed;
  int results_seen;
  int hold_req;
  int burst_left;

  // ---------------------------------------------------------------------------
  // Predictor
  function automatic logic [63:0] side(input logic [15:0] lo, input logic [15:0] hi);
    return (hi > lo) ? 64'(hi - lo) : 64'd0;
  endfunction

  function automatic bit overlaps_over_thr(input box_t a, input box_t b);
    logic [15:0] x1, y1, x2, y2;
    logic [63:0] inter, uni;
    x1 = (a.left > b.left) ? a.left : b.left;
    y1 = (a.top > b.top) ? a.top : b.top;
    x2 = (a.right < b.right) ? a.right : b.right;
    y2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    inter = side(x1, x2) * side(y1, y2);
    uni = side(a.left, a.right) * side(a.top, a.bottom)
        + side(b.left, b.right) * side(b.top, b.bottom) - inter;
    if (uni == 0) return 1'b0;  // zero union: never suppresses
    return (inter << 16) > (64'(nms_thr) * uni);
  endfunction

  function automatic bit outranks(input box_t a, input box_t b);
    if (a.cls != b.cls) return a.cls > b.cls;
    return a.conf > b.conf;
  endfunction

  // Sort, suppress per class and queue the survivors of the open set
  function automatic void close_set();
    int    ord[NBOX];
    bit    keep[NBOX];
    int    n, i, j, key;
    kept_t r;
    kept_t res[$];
    n = open_set.size();
    for (i = 0; i < n; i++) begin
      key = i;
      j = i;
      while (j > 0 && outranks(open_set[key], open_set[ord[j-1]])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    for (i = 0; i < n; i++) keep[i] = open_set[ord[i]].conf != 0;
    for (i = 0; i < n; i++) begin
      if (!keep[i]) continue;
      for (j = i + 1; j < n; j++) begin
        if (open_set[ord[j]].cls != open_set[ord[i]].cls) break;
        if (keep[j] && overlaps_over_thr(open_set[ord[i]], open_set[ord[j]]))
          keep[j] = 1'b0;
      end
    end
    for (i = 0; i < n; i++) begin
      if (!keep[i]) continue;
      r = '0;
      r.b = open_set[ord[i]];
      r.ovf = open_ovf;
      res.push_back(r);
    end
    if (res.size() == 0) begin
      r = '0;
      r.empty = 1'b1;
      r.ovf = open_ovf;
      res.push_back(r);
    end
    res[res.size()-1].last = 1'b1;
    foreach (res[k]) kept_q.push_back(res[k]);
    open_set.delete();
    open_ovf = 1'b0;
    sets_closed++;
  endfunction

  function automatic void take_box(input box_t b, input bit last);
    if (open_set.size() < NBOX) open_set.push_back(b);
    else open_ovf = 1'b1;
    if (last) close_set();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  task automatic send_box(input box_t b, input bit last, input bit typed, input kept_t r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    boxes_sent++;
    if (typed) begin
      // expectation comes from the table; the open set is still closed here
      void'(kept_q.size());
      open_set.delete();
      open_ovf = 1'b0;
      kept_q.push_back(r);
      sets_closed++;
    end else begin
      take_box(b, last);
    end
  endtask

  task automatic drain_results();
    while (kept_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    drain_results();
    in_tvalid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    nms_thr = v;
  endtask

  // Clustered boxes so that overlaps are common; some wide or reversed ones
  function automatic box_t rand_box(input logic [15:0] ox, input logic [15:0] oy,
                                    input int ncls);
    box_t b;
    int   sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      b = 88'({$urandom(), $urandom(), $urandom()});
    end else begin
      b.left   = ox + 16'($urandom_range(0, 40));
      b.top    = oy + 16'($urandom_range(0, 40));
      b.right  = (b.left > 16'hffff - 100) ? 16'hffff : b.left + 16'($urandom_range(0, 100));
      b.bottom = (b.top > 16'hffff - 100) ? 16'hffff : b.top + 16'($urandom_range(0, 100));
      if (sel == 1) {b.left, b.right} = {b.right, b.left};  // reversed corners
      b.conf = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom());
      if (sel == 2) b.conf = 16'hffff;
      b.cls = (sel == 3) ? 8'($urandom()) : 8'($urandom_range(0, ncls - 1));
    end
    return b;
  endfunction

  task automatic send_set(input int n);
    logic [15:0] ox, oy;
    int          ncls, i;
    ox = 16'($urandom_range(0, 65535));
    oy = 16'($urandom_range(0, 65535));
    ncls = $urandom_range(1, 3);
    for (i = 0; i < n; i++) send_box(rand_box(ox, oy, ncls), i == n - 1, 1'b0, '0);
  endtask

  function automatic row_t mk_row(input box_t b, input bit last, input bit typed,
                                  input kept_t r);
    row_t x;
    x.b = b;
    x.last = last;
    x.typed = typed;
    x.r = r;
    return x;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern plus a long hold-off on request
  always @(posedge clk) begin : rx_stall
    int hold_cnt;
    int mode_cnt;
    int mode;
    if (hold_req != 0 && hold_cnt == 0) begin
      hold_cnt = HOLD_LEN;
      hold_req = 0;
    end
    if (mode_cnt == 0) begin
      mode_cnt = $urandom_range(20, 120);
      mode = $urandom_range(0, 2);
    end
    mode_cnt--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
    $display("MISMATCH t=%0t %s: expected %0h, got %0h", $realtime, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : check_and_watch
    int    idle_cycles;
    kept_t w;
    box_t  g;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      g = out_tdata;
      if (kept_q.size() == 0) begin
        $display("MISMATCH t=%0t unexpected result %h", $realtime, out_tdata);
        errors++;
      end else begin
        w = kept_q.pop_front();
        if (g.left != w.b.left)     report("left_x", w.b.left, g.left);
        if (g.top != w.b.top)       report("top_y", w.b.top, g.top);
        if (g.right != w.b.right)   report("right_x", w.b.right, g.right);
        if (g.bottom != w.b.bottom) report("bottom_y", w.b.bottom, g.bottom);
        if (g.conf != w.b.conf)     report("confidence", w.b.conf, g.conf);
        if (g.cls != w.b.cls)       report("class", 16'(w.b.cls), 16'(g.cls));
        if (out_tuser[0] != w.empty)
          report("empty_set", 16'(w.empty), 16'(out_tuser[0]));
        if (out_tuser[1] != w.ovf)
          report("overflowed", 16'(w.ovf), 16'(out_tuser[1]));
        if (out_tlast != w.last)
          report("last_result", 16'(w.last), 16'(out_tlast));
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("** class_aware_box_nms: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  initial begin : stimulus
    row_t        rows[$];
    kept_t       r;
    logic [15:0] thr_list[4];
    int          p, budget, start;
    bit          passed;

    nms_thr = cabn_pkg::THR_RESET;
    open_ovf = 1'b0;
    errors = 0;
    hold_req = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets at the reset threshold
    r = '0; r.empty = 1'b1; r.last = 1'b1;
    rows.push_back(mk_row('0, 1'b1, 1'b1, r));                              // all zero: empty
    r = '0; r.b = {8'hff, 16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0}; r.last = 1'b1;
    rows.push_back(mk_row(r.b, 1'b1, 1'b1, r));                             // full frame
    r = '0; r.b = {8'h00, 16'h0001, 16'h0000, 16'h0000, 16'hffff, 16'hffff}; r.last = 1'b1;
    rows.push_back(mk_row(r.b, 1'b1, 1'b1, r));                             // reversed corners
    // same class, near-identical boxes, tied scores keep arrival order
    rows.push_back(mk_row({8'd5, 16'd100, 16'd60, 16'd60, 16'd10, 16'd10}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd5, 16'd200, 16'd60, 16'd60, 16'd10, 16'd10}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd5, 16'd200, 16'd61, 16'd60, 16'd10, 16'd10}, 1'b1, 1'b0, '0));
    // same boxes over different classes: nothing suppressed across classes
    rows.push_back(mk_row({8'd0, 16'd900, 16'd50, 16'd50, 16'd0, 16'd0}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd255, 16'd10, 16'd50, 16'd50, 16'd0, 16'd0}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd7, 16'd500, 16'd50, 16'd50, 16'd0, 16'd0}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd7, 16'd400, 16'd49, 16'd50, 16'd1, 16'd0}, 1'b1, 1'b0, '0));
    // zero-area boxes: union zero, both kept
    rows.push_back(mk_row({8'd3, 16'd40, 16'd20, 16'd20, 16'd20, 16'd20}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd3, 16'd30, 16'd20, 16'd20, 16'd20, 16'd20}, 1'b1, 1'b0, '0));
    // zero score dropped beside a kept box, and half-overlap at the threshold
    rows.push_back(mk_row({8'd1, 16'd0, 16'd100, 16'd100, 16'd0, 16'd0}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd1, 16'd9, 16'd100, 16'd100, 16'd0, 16'd0}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd1, 16'd8, 16'd100, 16'd150, 16'd0, 16'd50}, 1'b0, 1'b0, '0));
    rows.push_back(mk_row({8'd1, 16'd7, 16'd100, 16'd133, 16'd0, 16'd33}, 1'b1, 1'b0, '0));
    foreach (rows[k]) send_box(rows[k].b, rows[k].last, rows[k].typed, rows[k].r);

    // Random phases over several thresholds, extremes included
    thr_list[0] = 16'd0;
    thr_list[1] = 16'hffff;
    thr_list[2] = 16'($urandom());
    thr_list[3] = 16'h4000;
    for (p = 0; p < 4; p++) begin
      write_threshold(thr_list[p]);
      budget = 20;
      start = boxes_sent;
      if (p == 1) hold_req = 1;  // block fills up while the receiver holds off
      if (p == 2) send_set(NBOX + 2);  // store overflows, last flag on an ignored box
      while (boxes_sent - start < budget) begin
        send_set(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8));
        if ($urandom_range(0, 4) == 0) begin
          in_tvalid <= 1'b0;
          drain_results();
        end
      end
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    drain_results();
    repeat (200) @(posedge clk);
    passed = (errors == 0) && (kept_q.size() == 0);
    $display("covered %0d boxes in %0d sets, %0d results, thresholds 0.5, 0, max and others",
             boxes_sent, sets_closed, results_seen);
    $display("mismatches: %0d, results outstanding: %0d", errors, kept_q.size());
    if (passed)
      $display("** class_aware_box_nms: PASSED **");
    else
      $display("** class_aware_box_nms: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
